### rtl/cau_pkg.sv
package cau_pkg;

   localparam int FRAC_BITS = 16;
   // Quotient bits per divide: 32 integer bits plus FRAC_BITS + 1 fraction bits.
   localparam int QBITS = 32 + FRAC_BITS + 1;

   typedef enum logic [3:0] {
      FUNC_ADD  = 4'd0,
      FUNC_SUB  = 4'd1,
      FUNC_MUL  = 4'd2,
      FUNC_DIV  = 4'd3,
      FUNC_NEG  = 4'd4,
      FUNC_CONJ = 4'd5,
      FUNC_REAL = 4'd6,
      FUNC_IMAG = 4'd7,
      FUNC_PASS = 4'd8
   } func_type;

   typedef struct packed {
      logic [3:0]         func;
      logic signed [31:0] a_re;
      logic signed [31:0] a_im;
      logic signed [31:0] b_re;
      logic signed [31:0] b_im;
   } req_type;

   typedef struct packed {
      logic signed [31:0] res_re;
      logic signed [31:0] res_im;
      logic               div_zero;
      logic               overflow;
   } rsp_type;

   typedef struct packed {
      logic             is_div;
      logic             neg_re;
      logic             neg_im;
      logic             big_re;
      logic             big_im;
      logic [63:0]      d;
      logic [63:0]      rem_re;
      logic [63:0]      rem_im;
      logic [QBITS-1:0] low_re;
      logic [QBITS-1:0] low_im;
      logic [QBITS-1:0] q_re;
      logic [QBITS-1:0] q_im;
      rsp_type          res;
   } cell_type;

   // Clamps a sign and magnitude pair to signed 32 bits; the top bit flags saturation.
   function automatic logic [32:0] saturate(input logic neg, input logic [63:0] mag);
      logic [32:0] r;
      if (neg) begin
         if (mag > 64'h8000_0000) r = {1'b1, 32'h8000_0000};
         else r = {1'b0, 32'(~mag[31:0] + 32'd1)};
      end else begin
         if (mag > 64'h7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
         else r = {1'b0, mag[31:0]};
      end
      return r;
   endfunction

endpackage

### rtl/cau_front.sv
module cau_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  cau_pkg::req_type  in_data,
   output logic              out_valid,
   output cau_pkg::cell_type out_cell
);

   function automatic logic [32:0] sat33(input logic [32:0] s);
      logic [32:0] m;
      m = s[32] ? (~s + 33'd1) : s;
      return cau_pkg::saturate(s[32], 64'(m));
   endfunction

   // Stage 1: products and the results of the simple functions.
   logic                 v1_ff;
   logic [3:0]           func1_ff;
   logic signed [63:0]   p_aa_ff, p_bb_ff, p_ab_ff, p_ba_ff, p_dr_ff, p_di_ff;
   logic signed [63:0]   p_aa_in, p_bb_in, p_ab_in, p_ba_in, p_dr_in, p_di_in;
   cau_pkg::rsp_type     simple1_ff, simple1_in;
   logic [32:0]          ext_are, ext_aim, ext_bre, ext_bim;
   logic [32:0]          sr, si;

   assign ext_are = {in_data.a_re[31], in_data.a_re};
   assign ext_aim = {in_data.a_im[31], in_data.a_im};
   assign ext_bre = {in_data.b_re[31], in_data.b_re};
   assign ext_bim = {in_data.b_im[31], in_data.b_im};

   always_comb begin
      p_aa_in = in_data.a_re * in_data.b_re;
      p_bb_in = in_data.a_im * in_data.b_im;
      p_ab_in = in_data.a_re * in_data.b_im;
      p_ba_in = in_data.b_re * in_data.a_im;
      p_dr_in = in_data.b_re * in_data.b_re;
      p_di_in = in_data.b_im * in_data.b_im;
      sr = '0;
      si = '0;
      simple1_in = '0;
      case (in_data.func)
         cau_pkg::FUNC_ADD: begin
            sr = sat33(ext_are + ext_bre);
            si = sat33(ext_aim + ext_bim);
         end
         cau_pkg::FUNC_SUB: begin
            sr = sat33(ext_are - ext_bre);
            si = sat33(ext_aim - ext_bim);
         end
         cau_pkg::FUNC_NEG: begin
            sr = sat33(33'd0 - ext_are);
            si = sat33(33'd0 - ext_aim);
         end
         cau_pkg::FUNC_CONJ: begin
            sr = sat33(ext_are);
            si = sat33(33'd0 - ext_aim);
         end
         cau_pkg::FUNC_REAL: sr = sat33(ext_are);
         cau_pkg::FUNC_IMAG: sr = sat33(ext_aim);
         cau_pkg::FUNC_PASS: begin
            sr = sat33(ext_are);
            si = sat33(ext_aim);
         end
         default: ;
      endcase
      simple1_in.res_re   = sr[31:0];
      simple1_in.res_im   = si[31:0];
      simple1_in.overflow = sr[32] | si[32];
   end

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (advance) v1_ff <= in_valid;
      if (advance) begin
         func1_ff   <= in_data.func;
         p_aa_ff    <= p_aa_in;
         p_bb_ff    <= p_bb_in;
         p_ab_ff    <= p_ab_in;
         p_ba_ff    <= p_ba_in;
         p_dr_ff    <= p_dr_in;
         p_di_ff    <= p_di_in;
         simple1_ff <= simple1_in;
      end
   end

   // Stage 2: sums of products as sign and magnitude, and the denominator.
   logic             v2_ff;
   logic [3:0]       func2_ff;
   cau_pkg::rsp_type simple2_ff;
   logic             neg_re_ff, neg_im_ff, neg_re_in, neg_im_in;
   logic [63:0]      mag_re_ff, mag_im_ff, mag_re_in, mag_im_in, d_ff, d_in;
   logic [64:0]      s_re, s_im;

   always_comb begin
      if (func1_ff == cau_pkg::FUNC_DIV) begin
         s_re = {p_aa_ff[63], p_aa_ff} + {p_bb_ff[63], p_bb_ff};
         s_im = {p_ba_ff[63], p_ba_ff} - {p_ab_ff[63], p_ab_ff};
      end else begin
         s_re = {p_aa_ff[63], p_aa_ff} - {p_bb_ff[63], p_bb_ff};
         s_im = {p_ab_ff[63], p_ab_ff} + {p_ba_ff[63], p_ba_ff};
      end
      neg_re_in = s_re[64];
      neg_im_in = s_im[64];
      mag_re_in = s_re[64] ? 64'(65'd0 - s_re) : s_re[63:0];
      mag_im_in = s_im[64] ? 64'(65'd0 - s_im) : s_im[63:0];
      d_in      = 64'(p_dr_ff) + 64'(p_di_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (advance) v2_ff <= v1_ff;
      if (advance) begin
         func2_ff   <= func1_ff;
         simple2_ff <= simple1_ff;
         neg_re_ff  <= neg_re_in;
         neg_im_ff  <= neg_im_in;
         mag_re_ff  <= mag_re_in;
         mag_im_ff  <= mag_im_in;
         d_ff       <= d_in;
      end
   end

   // Stage 3: multiply rounding, divider setup.
   logic              v3_ff;
   cau_pkg::cell_type cell_ff, cell_in;
   logic [32:0]       mr, mi;
   localparam logic [63:0] HALF = 64'(1) << (cau_pkg::FRAC_BITS - 1);

   always_comb begin
      mr = cau_pkg::saturate(neg_re_ff, (mag_re_ff + HALF) >> cau_pkg::FRAC_BITS);
      mi = cau_pkg::saturate(neg_im_ff, (mag_im_ff + HALF) >> cau_pkg::FRAC_BITS);
      cell_in        = '0;
      cell_in.neg_re = neg_re_ff;
      cell_in.neg_im = neg_im_ff;
      cell_in.d      = d_ff;
      // The integer part of the quotient reaches 2^32 exactly when n / 2^32 >= d.
      cell_in.big_re = (mag_re_ff >> 32) >= d_ff;
      cell_in.big_im = (mag_im_ff >> 32) >= d_ff;
      cell_in.rem_re = mag_re_ff >> 32;
      cell_in.rem_im = mag_im_ff >> 32;
      cell_in.low_re = {mag_re_ff[31:0], (cau_pkg::FRAC_BITS + 1)'(0)};
      cell_in.low_im = {mag_im_ff[31:0], (cau_pkg::FRAC_BITS + 1)'(0)};
      case (func2_ff)
         cau_pkg::FUNC_MUL: begin
            cell_in.res.res_re   = mr[31:0];
            cell_in.res.res_im   = mi[31:0];
            cell_in.res.overflow = mr[32] | mi[32];
         end
         cau_pkg::FUNC_DIV: begin
            if (d_ff == 64'd0) cell_in.res.div_zero = 1'b1;
            else cell_in.is_div = 1'b1;
         end
         default: cell_in.res = simple2_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (advance) v3_ff <= v2_ff;
      if (advance) cell_ff <= cell_in;
   end

   assign out_valid = v3_ff;
   assign out_cell  = cell_ff;

endmodule

### rtl/cau_div_cell.sv
module cau_div_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  cau_pkg::cell_type in_cell,
   output logic              out_valid,
   output cau_pkg::cell_type out_cell
);

   // One restoring step for both parts: shift in a numerator bit, subtract d if it fits.
   logic              valid_ff;
   cau_pkg::cell_type cell_ff, cell_in;
   logic [64:0]       sh_re, sh_im;
   logic              fit_re, fit_im;

   always_comb begin
      sh_re  = {in_cell.rem_re, in_cell.low_re[cau_pkg::QBITS-1]};
      sh_im  = {in_cell.rem_im, in_cell.low_im[cau_pkg::QBITS-1]};
      fit_re = sh_re >= {1'b0, in_cell.d};
      fit_im = sh_im >= {1'b0, in_cell.d};
      cell_in        = in_cell;
      cell_in.rem_re = fit_re ? 64'(sh_re - {1'b0, in_cell.d}) : sh_re[63:0];
      cell_in.rem_im = fit_im ? 64'(sh_im - {1'b0, in_cell.d}) : sh_im[63:0];
      cell_in.low_re = in_cell.low_re << 1;
      cell_in.low_im = in_cell.low_im << 1;
      cell_in.q_re   = {in_cell.q_re[cau_pkg::QBITS-2:0], fit_re};
      cell_in.q_im   = {in_cell.q_im[cau_pkg::QBITS-2:0], fit_im};
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (advance) valid_ff <= in_valid;
      if (advance) cell_ff <= cell_in;
   end

   assign out_valid = valid_ff;
   assign out_cell  = cell_ff;

endmodule

### rtl/complex_arithmetic_unit_top.sv
// Complex ALU on signed Q16.16 operands: add, subtract, multiply, divide, negate,
// conjugate, real part, imaginary part and pass, with saturation and a zero-divisor
// flag. It takes one beat per cycle while no finished result is stalled and returns
// results in order through the front stages, a row of divider cells that each
// produce one quotient bit, and an output register; every function goes through
// the same pipeline. The whole pipeline holds while a finished result is stalled.
module complex_arithmetic_unit_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cau_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cau_pkg::rsp_type rsp_data
);

   logic              advance;
   logic              rsp_valid_ff;
   cau_pkg::rsp_type  rsp_data_ff, rsp_data_in;
   logic              chain_valid [0:cau_pkg::QBITS];
   cau_pkg::cell_type chain_cell  [0:cau_pkg::QBITS];

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   cau_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (chain_valid[0]),
      .out_cell  (chain_cell[0])
   );

   for (genvar i = 0; i < cau_pkg::QBITS; i++) begin : g_cell
      cau_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (chain_valid[i]),
         .in_cell   (chain_cell[i]),
         .out_valid (chain_valid[i+1]),
         .out_cell  (chain_cell[i+1])
      );
   end

   cau_pkg::cell_type last;
   logic [cau_pkg::QBITS:0] rnd_re, rnd_im;
   logic [63:0]             mag_re, mag_im;
   logic [32:0]             dr, di;

   always_comb begin
      last   = chain_cell[cau_pkg::QBITS];
      // Round half away from zero on the extra quotient bit.
      rnd_re = {1'b0, last.q_re} + 1'b1;
      rnd_im = {1'b0, last.q_im} + 1'b1;
      mag_re = last.big_re ? (64'(1) << 40) : 64'(rnd_re[cau_pkg::QBITS:1]);
      mag_im = last.big_im ? (64'(1) << 40) : 64'(rnd_im[cau_pkg::QBITS:1]);
      dr     = cau_pkg::saturate(last.neg_re, mag_re);
      di     = cau_pkg::saturate(last.neg_im, mag_im);
      if (last.is_div) begin
         rsp_data_in.res_re   = dr[31:0];
         rsp_data_in.res_im   = di[31:0];
         rsp_data_in.div_zero = 1'b0;
         rsp_data_in.overflow = dr[32] | di[32];
      end else begin
         rsp_data_in = last.res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (advance) rsp_valid_ff <= chain_valid[cau_pkg::QBITS];
      if (advance) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### rtl/cau_checker.sv
module cau_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input cau_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat dropped while stalled");

   a_dz_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.div_zero |->
         rsp_data.res_re == 0 && rsp_data.res_im == 0 && !rsp_data.overflow)
      else $error("zero divisor result not cleared");

   a_in_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output back-pressure");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind complex_arithmetic_unit_top cau_checker u_cau_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

### tb/sv/complex_arithmetic_unit_top_tb.sv
`timescale 1ns / 100ps

module complex_arithmetic_unit_top_tb;

   localparam int LATENCY   = cau_pkg::QBITS + 4;
   localparam int WDOG_MAX  = 4000;
   localparam int N_RANDOM  = 920;
   localparam int LONG_HOLD = 4 * LATENCY;

   logic             clock;
   logic             reset;
   logic             req_valid = 1'b0;
   logic             req_stall;
   cau_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   cau_pkg::rsp_type rsp_data;

   complex_arithmetic_unit_top DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   cau_pkg::req_type pending_ops[$];
   cau_pkg::rsp_type expected_results[$];
   int      mismatch_count = 0;
   int      beats_in = 0;
   int      beats_out = 0;
   int      idle_cycles = 0;
   int      ovf_seen = 0;
   int      dz_seen = 0;
   bit      calm = 0;          // no random idling in the last part of the run
   bit      hold_sender = 0;   // sender pauses while set
   bit      long_hold_on = 0;  // receiver makes one long hold-off when set
   int      hold_count = 0;
   bit      req_taken = 0;     // the offered beat was accepted at the last rising edge
   int      send_gap = 0;
   int      recv_gap = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Clamps a wide signed value to 32 bits.
   function automatic logic [32:0] clamp32(input logic signed [127:0] v);
      if (v > 128'sd2147483647) return {1'b1, 32'h7FFF_FFFF};
      if (v < -128'sd2147483648) return {1'b1, 32'h8000_0000};
      return {1'b0, v[31:0]};
   endfunction

   // Round-half-away-from-zero of n / 2^FRAC_BITS.
   function automatic logic signed [127:0] round_shift(input logic signed [127:0] n);
      logic [127:0] mag;
      mag = n < 0 ? -n : n;
      mag = (mag + (128'd1 << (cau_pkg::FRAC_BITS - 1))) >> cau_pkg::FRAC_BITS;
      return n < 0 ? -$signed(mag) : $signed(mag);
   endfunction

   // Round-half-away-from-zero of n * 2^FRAC_BITS / d, d positive.
   function automatic logic signed [127:0] round_div(input logic signed [127:0] n,
                                                     input logic [127:0] d);
      logic [127:0] mag;
      mag = n < 0 ? -n : n;
      mag = ((mag << (cau_pkg::FRAC_BITS + 1)) / d + 128'd1) >> 1;
      return n < 0 ? -$signed(mag) : $signed(mag);
   endfunction

   function automatic cau_pkg::rsp_type compute_result(input cau_pkg::req_type op);
      cau_pkg::rsp_type r;
      logic signed [127:0] ar, ai, br, bi, pre, pim;
      logic [127:0] den;
      logic [32:0] cr, ci;
      ar = op.a_re; ai = op.a_im; br = op.b_re; bi = op.b_im;
      r = '0;
      pre = 0; pim = 0;
      case (op.func)
         cau_pkg::FUNC_ADD:  begin pre = ar + br; pim = ai + bi; end
         cau_pkg::FUNC_SUB:  begin pre = ar - br; pim = ai - bi; end
         cau_pkg::FUNC_MUL: begin
            pre = round_shift(ar * br - ai * bi);
            pim = round_shift(ar * bi + br * ai);
         end
         cau_pkg::FUNC_DIV: begin
            den = br * br + bi * bi;
            if (den == 0) r.div_zero = 1'b1;
            else begin
               pre = round_div(ar * br + ai * bi, den);
               pim = round_div(br * ai - ar * bi, den);
            end
         end
         cau_pkg::FUNC_NEG:  begin pre = -ar; pim = -ai; end
         cau_pkg::FUNC_CONJ: begin pre = ar; pim = -ai; end
         cau_pkg::FUNC_REAL: pre = ar;
         cau_pkg::FUNC_IMAG: pre = ai;
         cau_pkg::FUNC_PASS: begin pre = ar; pim = ai; end
         default: ;
      endcase
      cr = clamp32(pre);
      ci = clamp32(pim);
      r.res_re = cr[31:0];
      r.res_im = ci[31:0];
      r.overflow = cr[32] | ci[32];
      return r;
   endfunction

   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'd0;
         3: return 32'hFFFF_FFFF;
         4, 5: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
         6: return 32'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
         default: return $urandom;
      endcase
   endfunction

   function automatic cau_pkg::req_type random_op();
      cau_pkg::req_type op;
      op.func = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                              : 4'($urandom_range(0, 8));
      op.a_re = pick_operand();
      op.a_im = pick_operand();
      op.b_re = pick_operand();
      op.b_im = pick_operand();
      if (op.func == cau_pkg::FUNC_DIV && $urandom_range(0, 9) == 0) begin
         op.b_re = 0;
         op.b_im = 0;
      end
      return op;
   endfunction

   task automatic queue_op(input logic [3:0] f, input logic [31:0] xr, input logic [31:0] xi,
                           input logic [31:0] yr, input logic [31:0] yi);
      cau_pkg::req_type op;
      op.func = f; op.a_re = xr; op.a_im = xi; op.b_re = yr; op.b_im = yi;
      pending_ops.push_back(op);
   endtask

   task automatic wait_drained();
      while (pending_ops.size() != 0 || req_valid || expected_results.size() != 0)
         @(posedge clock);
   endtask

   // Acceptance is judged at the rising edge, where the handshake takes place.
   always @(posedge clock) req_taken <= req_valid && !req_stall;

   // Driver: presents beats at the falling edge and holds a stalled one steady.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // Held until accepted.
      end else begin
         if (req_valid) begin
            beats_in++;
            expected_results.push_back(compute_result(req_data));
         end
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (!hold_sender && pending_ops.size() != 0) begin
            req_data  <= pending_ops.pop_front();
            req_valid <= 1'b1;
            if (!calm && $urandom_range(0, 15) == 0) send_gap = $urandom_range(1, 10);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver stall, in random bursts or one long hold-off on request.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (long_hold_on && hold_count < LONG_HOLD) begin
         hold_count++;
         rsp_stall <= 1'b1;
      end else if (recv_gap > 0) begin
         recv_gap--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if (!calm && $urandom_range(0, 11) == 0) recv_gap = $urandom_range(1, 10);
      end
   end

   // Monitor: checks each accepted result beat against the oldest expectation.
   always @(posedge clock) begin
      cau_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         beats_out++;
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result beat: re=%h im=%h dz=%b ovf=%b",
                        rsp_data.res_re, rsp_data.res_im, rsp_data.div_zero,
                        rsp_data.overflow);
         end else begin
            want = expected_results.pop_front();
            if (want.overflow) ovf_seen++;
            if (want.div_zero) dz_seen++;
            if (rsp_data !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"mismatch on result %0d: expected re=%h im=%h dz=%b ovf=%b,",
                            " got re=%h im=%h dz=%b ovf=%b"},
                           beats_out, want.res_re, want.res_im, want.div_zero,
                           want.overflow, rsp_data.res_re, rsp_data.res_im,
                           rsp_data.div_zero, rsp_data.overflow);
            end
         end
      end
   end

   // Watchdog on cycles without any accepted beat.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else if (idle_cycles >= WDOG_MAX) begin
         $display("watchdog expired with %0d results outstanding",
                  expected_results.size());
         $display("complex_arithmetic_unit_top_tb: FAIL");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      reset = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed cases: every function, extremes, zero divisor and unused selectors.
      queue_op(cau_pkg::FUNC_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF);
      queue_op(cau_pkg::FUNC_ADD, 32'h0001_8000, 32'hFFFF_0000, 32'h0002_0000, 32'h0000_4000);
      queue_op(cau_pkg::FUNC_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
      queue_op(cau_pkg::FUNC_SUB, 32'h0003_0000, 32'h0001_0000, 32'h0001_0000, 32'h0003_0000);
      queue_op(cau_pkg::FUNC_MUL, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'hFFFF_0000);
      queue_op(cau_pkg::FUNC_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      queue_op(cau_pkg::FUNC_MUL, 32'h0000_0001, 32'h0000_0000, 32'h0000_8000, 32'h0000_0000);
      queue_op(cau_pkg::FUNC_MUL, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_8000, 32'h0000_0000);
      queue_op(cau_pkg::FUNC_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000);
      queue_op(cau_pkg::FUNC_DIV, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0000_0000, 32'h0000_0000);
      queue_op(cau_pkg::FUNC_DIV, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001, 32'h0000_0000);
      queue_op(cau_pkg::FUNC_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      queue_op(cau_pkg::FUNC_DIV, 32'h0000_0001, 32'h0000_0000, 32'h0003_0000, 32'h0000_0000);
      queue_op(cau_pkg::FUNC_NEG, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_op(cau_pkg::FUNC_CONJ, 32'h1234_5678, 32'h8000_0000, 32'h0, 32'h0);
      queue_op(cau_pkg::FUNC_REAL, 32'hDEAD_BEEF, 32'h1111_1111, 32'h5555_5555, 32'hAAAA_AAAA);
      queue_op(cau_pkg::FUNC_IMAG, 32'hDEAD_BEEF, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA);
      queue_op(cau_pkg::FUNC_PASS, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0);
      queue_op(4'd9,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_op(4'd15, 32'h7FFF_FFFF, 32'h0000_0001, 32'h0, 32'h0);
      wait_drained();

      // Long receiver hold-off while the sender keeps offering beats.
      for (int i = 0; i < 3 * LATENCY; i++) pending_ops.push_back(random_op());
      long_hold_on = 1'b1;
      wait_drained();
      long_hold_on = 1'b0;

      for (int i = 0; i < N_RANDOM; i++) begin
         pending_ops.push_back(random_op());
         if (i == N_RANDOM / 2) begin
            wait_drained();
            // Sender pauses with the pipeline drained.
            hold_sender = 1'b1;
            repeat (LATENCY + 5) @(posedge clock);
            hold_sender = 1'b0;
         end
      end
      while (pending_ops.size() > 200) @(posedge clock);
      calm = 1'b1;
      wait_drained();
      repeat (LATENCY + 10) @(posedge clock);

      $display("%0d beats sent, %0d results checked, %0d saturating, %0d zero divisors.",
               beats_in, beats_out, ovf_seen, dz_seen);
      if (mismatch_count == 0 && expected_results.size() == 0)
         $display("complex_arithmetic_unit_top_tb: PASS");
      else begin
         $display("%0d mismatches, %0d results missing", mismatch_count,
                  expected_results.size());
         $display("complex_arithmetic_unit_top_tb: FAIL");
      end
      $finish;
   end

endmodule
